// ===== hdl/fixed_array_table_engine_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the fixed array table engine
// Shared forms for concurrent checks with and without a reset qualifier.
// ---------------------------------------------------------------------------
`ifndef FIXED_ARRAY_TABLE_ENGINE_MACROS_SVH
`define FIXED_ARRAY_TABLE_ENGINE_MACROS_SVH

// check qualified by an active-low reset
`define FATE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check that also holds through reset
`define FATE_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/fate_pkg.sv =====
// ---------------------------------------------------------------------------
// fate_pkg
// Types, codes and sizes shared by the table engine controller and datapath.
// ---------------------------------------------------------------------------
package fate_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACT_W  = 3;
    localparam int POS_W  = 4;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 4;

    localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REVERSE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SEARCH  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SORT    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SORT,
        S_SEARCH,
        S_READ,
        S_REPLY
    } t_state;

    typedef enum logic [2:0] {
        EM_OK,
        EM_BAD,
        EM_MISS,
        EM_HIT,
        EM_WORD
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  do_ins;
        logic  do_del;
        logic  do_rev;
        logic  sort_clr;
        logic  sort_step;
        logic  idx_clr;
        logic  idx_inc;
        logic  emit;
        t_emit kind;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             pos_bad;
        logic             hit;
        logic             idx_last;
        logic             sort_done;
        logic             out_free;
    } t_stat;

endpackage

// ===== hdl/fate_datapath.sv =====
// ---------------------------------------------------------------------------
// fate_datapath
// Table registers, shift/mirror/sort lanes, walk counter and output register.
// ---------------------------------------------------------------------------
module fate_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fate_pkg::t_cmd                   i_cmd,
    output fate_pkg::t_stat                  o_stat,
    input  logic [fate_pkg::ACT_W-1:0]       i_action,
    input  logic [fate_pkg::POS_W-1:0]       i_position,
    input  logic [fate_pkg::WORD_W-1:0]      i_value,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [fate_pkg::STAT_W-1:0]      o_status,
    output logic [fate_pkg::SLOT_W-1:0]      o_slot_index,
    output logic [fate_pkg::WORD_W-1:0]      o_data,
    output logic                             o_last
);

    logic [fate_pkg::WORD_W-1:0] r_tab   [fate_pkg::DEPTH];
    logic [fate_pkg::WORD_W-1:0] n_tab   [fate_pkg::DEPTH];
    logic [fate_pkg::WORD_W-1:0] ins_tab [fate_pkg::DEPTH];
    logic [fate_pkg::WORD_W-1:0] del_tab [fate_pkg::DEPTH];
    logic [fate_pkg::WORD_W-1:0] rev_tab [fate_pkg::DEPTH];
    logic [fate_pkg::WORD_W-1:0] srt_tab [fate_pkg::DEPTH];
    logic [fate_pkg::WORD_W-1:0] sh_r    [fate_pkg::DEPTH];
    logic [fate_pkg::WORD_W-1:0] sh_l    [fate_pkg::DEPTH];
    logic [fate_pkg::DEPTH-2:0]  swap;

    logic [fate_pkg::ACT_W-1:0]  r_act;
    logic [fate_pkg::POS_W-1:0]  r_pos;
    logic [fate_pkg::WORD_W-1:0] r_val;
    logic [fate_pkg::IDX_W-1:0]  r_idx;
    logic [fate_pkg::IDX_W-1:0]  n_idx;
    logic [fate_pkg::IDX_W-1:0]  r_phase;
    logic [fate_pkg::IDX_W-1:0]  n_phase;

    logic                        r_out_valid;
    logic [fate_pkg::STAT_W-1:0] r_status;
    logic [fate_pkg::SLOT_W-1:0] r_slot;
    logic [fate_pkg::WORD_W-1:0] r_data;
    logic                        r_last;
    logic [fate_pkg::STAT_W-1:0] n_status;
    logic [fate_pkg::SLOT_W-1:0] n_slot;
    logic [fate_pkg::WORD_W-1:0] n_data;
    logic                        n_last;

    logic [31:0]                 pos_x;
    logic [fate_pkg::WORD_W-1:0] rd_word;
    logic [fate_pkg::IDX_W:0]    idx_p1;
    logic                        idx_last;

    assign pos_x    = 32'(r_pos);
    assign rd_word  = r_tab[r_idx];
    assign idx_p1   = {1'b0, r_idx} + 1'b1;
    assign idx_last = (r_idx == fate_pkg::IDX_W'(fate_pkg::DEPTH - 1));

    for (genvar k = 0; k < fate_pkg::DEPTH - 1; k++) begin : g_cmp
        assign swap[k] = ($signed(r_tab[k]) > $signed(r_tab[k+1]))
                         && (r_phase[0] == 1'(k % 2));
    end

    for (genvar k = 0; k < fate_pkg::DEPTH; k++) begin : g_lane
        localparam logic [31:0] KP1 = 32'(k + 1);

        if (k == 0) begin : g_first
            assign sh_r[k]    = r_val;
            assign srt_tab[k] = swap[k] ? r_tab[k+1] : r_tab[k];
        end else begin : g_rest
            assign sh_r[k] = r_tab[k-1];
            if (k == fate_pkg::DEPTH - 1) begin : g_end
                assign srt_tab[k] = swap[k-1] ? r_tab[k-1] : r_tab[k];
            end else begin : g_mid
                assign srt_tab[k] = swap[k]   ? r_tab[k+1] :
                                    swap[k-1] ? r_tab[k-1] : r_tab[k];
            end
        end

        if (k == fate_pkg::DEPTH - 1) begin : g_tail
            assign sh_l[k] = '0;
        end else begin : g_body
            assign sh_l[k] = r_tab[k+1];
        end

        assign ins_tab[k] = (pos_x == KP1) ? r_val :
                            (pos_x < KP1)  ? sh_r[k] : r_tab[k];
        assign del_tab[k] = (pos_x <= KP1) ? sh_l[k] : r_tab[k];
        assign rev_tab[k] = r_tab[fate_pkg::DEPTH-1-k];
    end

    always_comb begin
        priority if (i_cmd.do_ins) begin
            n_tab = ins_tab;
        end else if (i_cmd.do_del) begin
            n_tab = del_tab;
        end else if (i_cmd.do_rev) begin
            n_tab = rev_tab;
        end else if (i_cmd.sort_step) begin
            n_tab = srt_tab;
        end else begin
            n_tab = r_tab;
        end
    end

    always_comb begin
        priority if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_comb begin
        priority if (i_cmd.sort_clr) begin
            n_phase = '0;
        end else if (i_cmd.sort_step) begin
            n_phase = r_phase + 1'b1;
        end else begin
            n_phase = r_phase;
        end
    end

    always_comb begin
        n_status = fate_pkg::ST_OK;
        n_slot   = '0;
        n_data   = '0;
        n_last   = 1'b1;
        unique case (i_cmd.kind)
            fate_pkg::EM_OK: begin
            end
            fate_pkg::EM_BAD: begin
                n_status = fate_pkg::ST_BADPOS;
            end
            fate_pkg::EM_MISS: begin
                n_status = fate_pkg::ST_NOTFOUND;
            end
            fate_pkg::EM_HIT: begin
                n_slot = fate_pkg::SLOT_W'(idx_p1);
                n_data = rd_word;
            end
            fate_pkg::EM_WORD: begin
                n_slot = fate_pkg::SLOT_W'(idx_p1);
                n_data = rd_word;
                n_last = idx_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fate_pkg::DEPTH; k++) begin
                r_tab[k] <= '0;
            end
            r_idx       <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_tab   <= n_tab;
            r_idx   <= n_idx;
            r_phase <= n_phase;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (i_cmd.emit) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_data   <= n_data;
            r_last   <= n_last;
        end
    end

    assign o_stat.act       = r_act;
    assign o_stat.pos_bad   = ((r_act == fate_pkg::ACT_INSERT) || (r_act == fate_pkg::ACT_DELETE))
                              && ((r_pos == '0) || (pos_x > 32'(fate_pkg::DEPTH)));
    assign o_stat.hit       = (rd_word == r_val);
    assign o_stat.idx_last  = idx_last;
    assign o_stat.sort_done = (r_phase == fate_pkg::IDX_W'(fate_pkg::DEPTH - 1));
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_slot_index = r_slot;
    assign o_data       = r_data;
    assign o_last       = r_last;

endmodule

// ===== hdl/fate_ctrl.sv =====
// ---------------------------------------------------------------------------
// fate_ctrl
// Command sequencer: decodes the action and steps the datapath through it.
// ---------------------------------------------------------------------------
module fate_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  fate_pkg::t_stat i_stat,
    output fate_pkg::t_cmd  o_cmd
);

    fate_pkg::t_state r_state;
    fate_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fate_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fate_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = fate_pkg::S_DECODE;
                end
            end
            fate_pkg::S_DECODE: begin
                unique case (i_stat.act)
                    fate_pkg::ACT_INSERT,
                    fate_pkg::ACT_DELETE,
                    fate_pkg::ACT_REVERSE: n_state = fate_pkg::S_REPLY;
                    fate_pkg::ACT_SEARCH:  n_state = fate_pkg::S_SEARCH;
                    fate_pkg::ACT_SORT:    n_state = fate_pkg::S_SORT;
                    fate_pkg::ACT_READ:    n_state = fate_pkg::S_READ;
                    default:               n_state = fate_pkg::S_IDLE;
                endcase
            end
            fate_pkg::S_SORT: begin
                if (i_stat.sort_done) begin
                    n_state = fate_pkg::S_REPLY;
                end
            end
            fate_pkg::S_SEARCH: begin
                if ((i_stat.hit || i_stat.idx_last) && i_stat.out_free) begin
                    n_state = fate_pkg::S_IDLE;
                end
            end
            fate_pkg::S_READ: begin
                if (i_stat.idx_last && i_stat.out_free) begin
                    n_state = fate_pkg::S_IDLE;
                end
            end
            fate_pkg::S_REPLY: begin
                if (i_stat.out_free) begin
                    n_state = fate_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fate_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = fate_pkg::EM_OK;
        o_in_stall = (r_state != fate_pkg::S_IDLE);
        unique case (r_state)
            fate_pkg::S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            fate_pkg::S_DECODE: begin
                unique case (i_stat.act)
                    fate_pkg::ACT_INSERT:  o_cmd.do_ins   = !i_stat.pos_bad;
                    fate_pkg::ACT_DELETE:  o_cmd.do_del   = !i_stat.pos_bad;
                    fate_pkg::ACT_REVERSE: o_cmd.do_rev   = 1'b1;
                    fate_pkg::ACT_SEARCH:  o_cmd.idx_clr  = 1'b1;
                    fate_pkg::ACT_SORT:    o_cmd.sort_clr = 1'b1;
                    fate_pkg::ACT_READ:    o_cmd.idx_clr  = 1'b1;
                    default: begin
                    end
                endcase
            end
            fate_pkg::S_SORT: begin
                o_cmd.sort_step = 1'b1;
            end
            fate_pkg::S_SEARCH: begin
                priority if (i_stat.hit) begin
                    o_cmd.emit = i_stat.out_free;
                    o_cmd.kind = fate_pkg::EM_HIT;
                end else if (i_stat.idx_last) begin
                    o_cmd.emit = i_stat.out_free;
                    o_cmd.kind = fate_pkg::EM_MISS;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            fate_pkg::S_READ: begin
                o_cmd.emit    = i_stat.out_free;
                o_cmd.idx_inc = i_stat.out_free;
                o_cmd.kind    = fate_pkg::EM_WORD;
            end
            fate_pkg::S_REPLY: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = i_stat.pos_bad ? fate_pkg::EM_BAD : fate_pkg::EM_OK;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/fixed_array_table_engine.sv =====
// ---------------------------------------------------------------------------
// fixed_array_table_engine
// Fixed table of signed words with insert, delete, reverse, search, sort
// and read-all commands, one command per input word.
// ---------------------------------------------------------------------------
//  channel | valid    | stall    | payload
//  input   | i_valid  | o_stall  | i_action, i_position, i_value
//  output  | o_valid  | i_stall  | o_status, o_slot_index, o_data, o_last
//
//  Insert, delete and reverse pass through decode and reply; sort is paced by
//  the odd-even exchange phase counter; search and read-all by the walk
//  counter, one word per cycle (read-all only while the output is free).
//  Every result goes through a single output register; a stall on the output
//  holds the sequencer at the next result. Reset is synchronous and clears
//  the table to zero with no clearing pass.
// ---------------------------------------------------------------------------
module fixed_array_table_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic        [fate_pkg::ACT_W-1:0]   i_action,
    input  logic        [fate_pkg::POS_W-1:0]   i_position,
    input  logic signed [fate_pkg::WORD_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic        [fate_pkg::STAT_W-1:0]  o_status,
    output logic        [fate_pkg::SLOT_W-1:0]  o_slot_index,
    output logic signed [fate_pkg::WORD_W-1:0]  o_data,
    output logic                                o_last
);

    fate_pkg::t_cmd  cmd;
    fate_pkg::t_stat stat;
    logic [fate_pkg::WORD_W-1:0] data_w;

    fate_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fate_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_out_stall  (i_stall),
        .o_out_valid  (o_valid),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_data       (data_w),
        .o_last       (o_last)
    );

    assign o_data = data_w;

endmodule

// ===== hdl/fate_checker.sv =====
// ---------------------------------------------------------------------------
// fate_checker
// Port-level checks on the table engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "fixed_array_table_engine_macros.svh"

module fate_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [fate_pkg::STAT_W-1:0]  o_status,
    input logic [fate_pkg::SLOT_W-1:0]  o_slot_index,
    input logic [fate_pkg::WORD_W-1:0]  o_data,
    input logic                         o_last
);

    `FATE_ASSERT_NR(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid && !o_stall, "not quiet after reset")

    `FATE_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_data) && $stable(o_status) && $stable(o_slot_index) && $stable(o_last), "stalled result word changed")

    `FATE_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "second command taken while busy")

    `FATE_ASSERT(a_badpos_word, i_clk, i_rst_n, o_valid && (o_status == fate_pkg::ST_BADPOS) |-> (o_slot_index == '0) && (o_data == '0) && o_last, "malformed bad-position word")

    `FATE_ASSERT(a_miss_word, i_clk, i_rst_n, o_valid && (o_status == fate_pkg::ST_NOTFOUND) |-> (o_slot_index == '0) && (o_data == '0) && o_last, "malformed not-found word")

endmodule

bind fixed_array_table_engine fate_checker u_fate_checker (.*);
